/* rtl/core/bswc_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the bounded stack with match count.
// No dependencies; imported by the interfaces and every module.
package bswc_pkg;

  localparam int DEPTH_DEF      = 256;
  localparam int DATA_WIDTH_DEF = 32;

  localparam int FUNC_W   = 3;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int CAP_W    = 9;
  localparam int MCOUNT_W = 9;

  localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

  // operation codes
  localparam logic [FUNC_W-1:0] OP_PUSH  = 3'd0;
  localparam logic [FUNC_W-1:0] OP_POP   = 3'd1;
  localparam logic [FUNC_W-1:0] OP_PEEK  = 3'd2;
  localparam logic [FUNC_W-1:0] OP_COUNT = 3'd3;
  localparam logic [FUNC_W-1:0] OP_CLEAR = 3'd4;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  // controller -> datapath
  typedef struct packed {
    logic start;     // input beat taken: latch item, launch first read
    logic cnt_step;  // compare one held entry, read the next
    logic finish;    // apply the operation and load the result register
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic count_go;  // incoming item is a count on a non-empty stack
    logic cnt_last;  // walk index sits on the top entry
    logic out_free;  // result register can take a new beat
  } dp_stat_t;

endpackage

/* rtl/core/bswc_cmd_if.sv */
`timescale 1ns / 1ps
// Input channel: valid/ready handshake carrying one operation beat.
// Depends on bswc_pkg.
interface bswc_cmd_if import bswc_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [FUNC_W-1:0]         func;
  logic signed [VALUE_W-1:0] value;

  modport source(output valid, func, value, input ready);
  modport sink(input valid, func, value, output ready);
endinterface

/* rtl/core/bswc_res_if.sv */
`timescale 1ns / 1ps
// Output channel: valid/ready handshake carrying one result beat.
// Depends on bswc_pkg.
interface bswc_res_if import bswc_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [STATUS_W-1:0]       status;
  logic signed [VALUE_W-1:0] top_value;
  logic [MCOUNT_W-1:0]       match_count;

  modport source(output valid, status, top_value, match_count, input ready);
  modport sink(input valid, status, top_value, match_count, output ready);
endinterface

/* rtl/core/bswc_ctrl.sv */
`timescale 1ns / 1ps
// Sequencing state machine for the stack: take a beat, walk for count,
// finish into the result register. Depends on bswc_pkg.
module bswc_ctrl import bswc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  dp_stat_t  stat,
  output ctrl_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CNT  = 3'b010,
    S_FIN  = 3'b100
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.start  = 1'b1;
          state_next = stat.count_go ? S_CNT : S_FIN;
        end
      end
      S_CNT: begin
        cmd.cnt_step = 1'b1;
        if (stat.cnt_last) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

/* rtl/core/bswc_dp.sv */
`timescale 1ns / 1ps
// Stack datapath: entry memory, occupancy, capacity register, count walk
// and the result register. Depends on bswc_pkg.
module bswc_dp import bswc_pkg::*; #(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [CAP_W-1:0]           cfg_wdata,
  input  logic [FUNC_W-1:0]          func,
  input  logic signed [VALUE_W-1:0]  value,
  input  ctrl_cmd_t                  cmd,
  output dp_stat_t                   stat,
  output logic                       res_valid,
  input  logic                       res_ready,
  output logic [STATUS_W-1:0]        res_status,
  output logic signed [VALUE_W-1:0]  res_top_value,
  output logic [MCOUNT_W-1:0]        res_match_count
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int OW = $clog2(DEPTH + 1);
  localparam int CW = (OW > CAP_W) ? OW : CAP_W;
  localparam int XW = (DATA_WIDTH > VALUE_W) ? DATA_WIDTH : VALUE_W;

  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic [DATA_WIDTH-1:0] rd_data;
  logic [AW-1:0]         rd_addr;
  logic                  rd_en;
  logic                  wr_en;

  logic [CAP_W-1:0]      capacity;
  logic [OW-1:0]         occ;
  logic [FUNC_W-1:0]     op;
  logic [DATA_WIDTH-1:0] word;
  logic [DATA_WIDTH-1:0] word_in;
  logic [OW-1:0]         idx;
  logic [OW-1:0]         hits;

  logic empty;
  logic full;

  // words keep their low DATA_WIDTH bits, zero above
  assign word_in = DATA_WIDTH'(XW'(unsigned'(value)));

  assign empty = (occ == '0);
  // occupancy never exceeds DEPTH, so this is occ >= min(capacity, DEPTH)
  assign full  = (CW'(occ) >= CW'(capacity)) || (occ == OW'(DEPTH));

  assign stat.count_go = (func == OP_COUNT) && !empty;
  assign stat.cnt_last = (idx == occ - 1'b1);
  assign stat.out_free = !res_valid || res_ready;

  always_comb begin
    if (cmd.cnt_step) begin
      rd_addr = AW'(idx + 1'b1);
    end else if (func == OP_COUNT) begin
      rd_addr = '0;
    end else begin
      rd_addr = AW'(occ - 1'b1);
    end
  end

  assign rd_en = cmd.start || cmd.cnt_step;
  assign wr_en = cmd.finish && (op == OP_PUSH) && !full;

  // entry store, one write and one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[AW'(occ)] <= word;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // item latch and count walk
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      op   <= func;
      word <= word_in;
      idx  <= '0;
      hits <= '0;
    end else if (cmd.cnt_step) begin
      idx <= idx + 1'b1;
      if (rd_data == word) begin
        hits <= hits + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (cfg_we) begin
      capacity <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= '0;
    end else if (cmd.finish) begin
      case (op)
        OP_PUSH:  if (!full) occ <= occ + 1'b1;
        OP_POP:   if (!empty) occ <= occ - 1'b1;
        OP_CLEAR: occ <= '0;
        default:  occ <= occ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.finish) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      res_status      <= ST_DONE;
      res_top_value   <= '0;
      res_match_count <= '0;
      case (op)
        OP_PUSH: begin
          if (full) res_status <= ST_FULL;
        end
        OP_POP, OP_PEEK: begin
          if (empty) begin
            res_status <= ST_EMPTY;
          end else begin
            res_top_value <= VALUE_W'(XW'(rd_data));
          end
        end
        OP_COUNT: begin
          if (empty) begin
            res_status <= ST_EMPTY;
          end else begin
            res_match_count <= MCOUNT_W'(hits);
          end
        end
        default: begin
          res_status <= ST_DONE;
        end
      endcase
    end
  end

  // a successful push grows the stack by exactly one
  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    wr_en |=> occ == OW'($past(occ) + 1'b1))
    else $error("push did not advance occupancy");

  // the count walk stays below the occupancy
  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.cnt_step |-> idx < occ)
    else $error("count walk beyond held entries");

  // a finished count never reports more hits than entries held
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (cmd.finish && op == OP_COUNT) |-> hits <= occ)
    else $error("match count exceeds occupancy");

endmodule

/* rtl/core/bounded_stack_with_count_core.sv */
`timescale 1ns / 1ps
// Top level of the bounded LIFO stack with match count.
// Depends on bswc_pkg, bswc_cmd_if, bswc_res_if, bswc_ctrl and bswc_dp.
//
// Usage:
//   cmd  - sink channel, one beat per operation (func, value). func selects
//          push, pop, peek, count matches or clear; other codes are no-ops.
//   res  - source channel, exactly one beat per command beat, in order:
//          status, top_value (pop/peek), match_count (count).
//   cfg  - cfg_we/cfg_wdata write the capacity limit; write only when idle.
// Timing:
//   Push, pop, peek, clear and unknown codes go from the cmd beat to the
//   result register through the memory read and then the finish step.
//   Count walks the held entries one memory read per cycle, then finishes.
//   The single read port of the entry memory sets this pace.
//   The next cmd beat is taken the cycle after a result is loaded.
// Reset (rst, synchronous): stack empty, capacity 256, no result pending.
//   Stored words are not cleared; only entries below the occupancy are used.
// Stall: a result waits in the output register while res.ready is low; the
//   next command is still taken and processed, and stops at its finish
//   step until the waiting beat has been taken.
module bounded_stack_with_count_core import bswc_pkg::*; #(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [CAP_W-1:0] cfg_wdata,
  bswc_cmd_if.sink         cmd,
  bswc_res_if.source       res
);

  ctrl_cmd_t ctrl_cmd;  // sequencer commands to the datapath
  dp_stat_t  dp_stat;   // datapath status back to the sequencer

  bswc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (cmd.valid),
    .in_ready (cmd.ready),
    .stat     (dp_stat),
    .cmd      (ctrl_cmd)
  );

  bswc_dp #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .func            (cmd.func),
    .value           (cmd.value),
    .cmd             (ctrl_cmd),
    .stat            (dp_stat),
    .res_valid       (res.valid),
    .res_ready       (res.ready),
    .res_status      (res.status),
    .res_top_value   (res.top_value),
    .res_match_count (res.match_count)
  );

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps
// Self-checking bench for bounded_stack_with_count_core: directed and random
// operation beats, each result checked against an in-bench stack predictor.
// Depends on bswc_pkg, bswc_cmd_if, bswc_res_if and the core RTL.
module tb;
  import bswc_pkg::*;

  // watchdog: longest run of cycles with no beat on either channel (longer
  // than a count on a full store, and than the long output hold-off)
  localparam int STALL_LIMIT   = 4000;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 8;
  localparam int TAIL_CYCLES   = 300;   // longer than the slowest count walk
  localparam int IDLE_PCT      = 8;
  localparam int REPORT_MAX    = 10;
  localparam int STORE_DEPTH   = DEPTH_DEF;
  localparam int FILL_PUSHES   = 270;   // overfills the saturated limit
  localparam int PHASE_OPS     = 160;
  localparam int NUM_PHASES    = 9;

  // codes with no operation behind them
  localparam logic [FUNC_W-1:0] OP_RSVD_A = 3'd5;
  localparam logic [FUNC_W-1:0] OP_RSVD_B = 3'd6;
  localparam logic [FUNC_W-1:0] OP_RSVD_C = 3'd7;

  localparam logic [CAP_W-1:0] CAP_ZERO = 9'd0;
  localparam logic [CAP_W-1:0] CAP_ONE  = 9'd1;
  localparam logic [CAP_W-1:0] CAP_TOP  = 9'd511;

  localparam logic signed [VALUE_W-1:0] WORD_MIN      = 32'sh8000_0000;
  localparam logic signed [VALUE_W-1:0] WORD_MAX      = 32'sh7fff_ffff;
  localparam logic signed [VALUE_W-1:0] WORD_ALL_ONES = -32'sd1;

  typedef struct packed {
    logic [FUNC_W-1:0]         func;
    logic signed [VALUE_W-1:0] value;
  } stack_op_t;

  typedef struct packed {
    logic [STATUS_W-1:0]       status;
    logic signed [VALUE_W-1:0] top_value;
    logic [MCOUNT_W-1:0]       match_count;
  } stack_result_t;

  logic             clk;
  logic             rst;
  logic             cfg_we;
  logic [CAP_W-1:0] cfg_wdata;

  bswc_cmd_if cmd_ch ();
  bswc_res_if res_ch ();

  bounded_stack_with_count_core dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd_ch),
    .res       (res_ch)
  );

  always #2 clk = ~clk;

  // Stimulus and expectations shared between the processes below.
  stack_op_t     pending_ops[$];
  stack_result_t expected_results[$];
  bit            quiet_mode;      // no random idling on either side
  int            hold_asked;      // bumped to request one long output hold-off
  int            mismatch_count;

  // Predictor state: its own copy of the store, fill level and capacity.
  logic signed [VALUE_W-1:0] model_mem [STORE_DEPTH];
  int unsigned               model_fill = 0;
  logic [CAP_W-1:0]          model_cap  = CAP_RESET;

  // Applies one operation to the predicted stack and returns its result.
  task automatic stack_predict(input logic [FUNC_W-1:0] op,
                               input logic signed [VALUE_W-1:0] word,
                               output stack_result_t r);
    int unsigned lim;
    r = '0;
    r.status = ST_DONE;
    // limit saturates at the store depth; zero capacity refuses every push
    lim = (model_cap > STORE_DEPTH) ? STORE_DEPTH : model_cap;
    case (op)
      OP_PUSH: begin
        // capacity may sit below the fill after a lowering write
        if (model_fill >= lim) begin
          r.status = ST_FULL;
        end else begin
          model_mem[model_fill] = word;
          model_fill++;
        end
      end
      OP_POP, OP_PEEK: begin
        if (model_fill == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.top_value = model_mem[model_fill-1];
          if (op == OP_POP) model_fill--;
        end
      end
      OP_COUNT: begin
        if (model_fill == 0) begin
          r.status = ST_EMPTY;
        end else begin
          for (int i = 0; i < model_fill; i++)
            if (model_mem[i] == word) r.match_count++;
        end
      end
      OP_CLEAR: model_fill = 0;
      default: ;  // spare codes: no change, zero result
    endcase
  endtask

  // Command driver: holds a beat until taken, otherwise idles now and then.
  // The prediction is made on the edge at which the beat is accepted.
  always @(posedge clk) begin : drive_cmd
    stack_result_t predicted;
    stack_op_t     next_op;
    if (rst) begin
      cmd_ch.valid <= 1'b0;
    end else begin
      if (cmd_ch.valid && cmd_ch.ready) begin
        stack_predict(cmd_ch.func, cmd_ch.value, predicted);
        expected_results.push_back(predicted);
      end
      if (!cmd_ch.valid || cmd_ch.ready) begin
        if (pending_ops.size() != 0 &&
            (quiet_mode || $urandom_range(0, 99) >= IDLE_PCT)) begin
          next_op = pending_ops.pop_front();
          cmd_ch.valid <= 1'b1;
          cmd_ch.func  <= next_op.func;
          cmd_ch.value <= next_op.value;
        end else begin
          cmd_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: checks each beat against the oldest expectation, and
  // drives ready with random stalls plus the requested long hold-off.
  int hold_served = 0;
  int hold_left   = 0;

  always @(posedge clk) begin : watch_res
    stack_result_t want;
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        if (expected_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_MAX)
            $display("%0t: result beat with nothing expected", $time);
        end else begin
          want = expected_results.pop_front();
          if (res_ch.status !== want.status || res_ch.top_value !== want.top_value ||
              res_ch.match_count !== want.match_count) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_MAX)
              $display("%0t: mismatch exp/got status %0d/%0d top %0d/%0d count %0d/%0d",
                       $time, want.status, res_ch.status, want.top_value,
                       res_ch.top_value, want.match_count, res_ch.match_count);
          end
        end
      end
      if (hold_served != hold_asked) begin
        hold_served <= hold_asked;
        hold_left   <= HOLD_CYCLES;
        res_ch.ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left   <= hold_left - 1;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= quiet_mode || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  // Watchdog: too long without any beat means the block has hung.
  int stall_cycles = 0;

  always @(posedge clk) begin
    if (!rst) begin
      if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT - 1) begin
        $display("RESULT: ERROR");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  task automatic queue_op(input logic [FUNC_W-1:0] op,
                          input logic signed [VALUE_W-1:0] word);
    stack_op_t item;
    item.func  = op;
    item.value = word;
    pending_ops.push_back(item);
  endtask

  // Words drawn six times in ten from a small pool so that counts find matches.
  function automatic logic signed [VALUE_W-1:0] pick_word();
    case ($urandom_range(0, 9))
      0: return WORD_MIN;
      1: return WORD_MAX;
      2: return 32'sd0;
      3: return WORD_ALL_ONES;
      4: return 32'sd1;
      5: return 32'sh5555_5555;
      default: return $urandom;
    endcase
  endfunction

  // Mixed operations, push-heavy so the stack climbs towards its limit.
  // Spare codes are sprinkled in but not counted.
  task automatic queue_random(input int n);
    int done;
    int pick;
    logic [FUNC_W-1:0] spare;
    done = 0;
    while (done < n) begin
      pick = $urandom_range(0, 99);
      done++;
      if (pick < 40) begin
        queue_op(OP_PUSH, pick_word());
      end else if (pick < 62) begin
        queue_op(OP_POP, $urandom);
      end else if (pick < 75) begin
        queue_op(OP_PEEK, $urandom);
      end else if (pick < 90) begin
        queue_op(OP_COUNT, pick_word());
      end else if (pick < 93) begin
        queue_op(OP_CLEAR, $urandom);
      end else begin
        spare = FUNC_W'(OP_RSVD_A + $urandom_range(0, 2));
        queue_op(spare, $urandom);
        done--;
      end
    end
  endtask

  // Wait until every beat has gone through and every result is back.
  task automatic drain();
    while (pending_ops.size() != 0 || cmd_ch.valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Capacity write; only called with the block idle.
  task automatic set_capacity(input logic [CAP_W-1:0] cap);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= cap;
    @(posedge clk);
    cfg_we    <= 1'b0;
    model_cap = cap;
  endtask

  initial begin : main_seq
    logic [CAP_W-1:0] phase_caps [NUM_PHASES];
    clk = 1'b0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    cmd_ch.valid = 1'b0;
    cmd_ch.func = OP_PUSH;
    cmd_ch.value = '0;
    res_ch.ready = 1'b0;
    quiet_mode = 1'b0;
    hold_asked = 0;
    mismatch_count = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed, at the reset capacity: empty-stack reads first.
    queue_op(OP_POP, 32'sd0);
    queue_op(OP_PEEK, 32'sd0);
    queue_op(OP_COUNT, 32'sd0);
    // field extremes, duplicate for a count of two
    queue_op(OP_PUSH, WORD_MIN);
    queue_op(OP_PUSH, WORD_MAX);
    queue_op(OP_PUSH, 32'sd0);
    queue_op(OP_PUSH, WORD_ALL_ONES);
    queue_op(OP_PUSH, WORD_ALL_ONES);
    queue_op(OP_PEEK, WORD_MAX);
    queue_op(OP_COUNT, WORD_ALL_ONES);
    // spare codes leave the stack alone
    queue_op(OP_RSVD_A, WORD_ALL_ONES);
    queue_op(OP_RSVD_B, WORD_MIN);
    queue_op(OP_RSVD_C, WORD_MAX);
    queue_op(OP_POP, 32'sd0);
    queue_op(OP_CLEAR, WORD_ALL_ONES);
    queue_op(OP_POP, 32'sd0);
    queue_op(OP_PUSH, 32'sd1);
    queue_op(OP_PUSH, 32'sd2);
    queue_op(OP_PUSH, 32'sd3);
    drain();

    // capacity dropped below the fill: pushes refused, rest works as usual
    set_capacity(CAP_ONE);
    queue_op(OP_PUSH, 32'sd9);
    queue_op(OP_COUNT, 32'sd2);
    repeat (4) queue_op(OP_POP, 32'sd0);
    drain();

    // zero capacity refuses even on an empty stack
    set_capacity(CAP_ZERO);
    queue_op(OP_PUSH, WORD_MAX);
    drain();

    // Fill past the saturated limit while the output is held off for a long
    // stretch: the result register backs up and the input has to stall.
    set_capacity(CAP_TOP);
    hold_asked++;
    repeat (FILL_PUSHES) queue_op(OP_PUSH, pick_word());
    queue_op(OP_COUNT, pick_word());
    queue_op(OP_PEEK, 32'sd0);
    queue_random(100);
    drain();

    // Random phases over a spread of capacities; the stack carries over,
    // so a smaller capacity often lands below the current fill.
    phase_caps[0] = CAP_ONE;
    phase_caps[1] = CAP_ZERO;
    phase_caps[2] = 9'd4;
    phase_caps[3] = 9'd16;
    phase_caps[4] = CAP_W'($urandom_range(2, 255));
    phase_caps[5] = CAP_RESET;
    phase_caps[6] = CAP_W'($urandom_range(257, 510));
    phase_caps[7] = 9'd3;
    phase_caps[8] = CAP_RESET;
    for (int p = 0; p < NUM_PHASES; p++) begin
      quiet_mode = (p == 5);  // one long stretch at full rate
      set_capacity(phase_caps[p]);
      queue_random(PHASE_OPS);
      drain();
      quiet_mode = 1'b0;
    end

    // anything arriving late shows up as an unexpected beat
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
